// ===== src/rscb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscb_pkg: shared types and constants of the sprite blitter
// register codes, decode phases, geometry and result records
// ----------------------------------------------------------------------------
package rscb_pkg;

	localparam int COORD_BITS_DEF = 11;
	localparam int COORD_BITS_MAX = 15;
	localparam int LIM_W          = COORD_BITS_MAX + 1;

	localparam int WORD_W   = 16;
	localparam int CFG_W    = 12;
	localparam int CFG_IDX_W = 3;
	localparam int PIX_W    = 11;
	localparam int COL_W    = 17;
	localparam int ROW_W    = 12;
	localparam int VROWS_W  = 14;

	localparam logic [CFG_W-1:0] SCREEN_W_RST = 12'd800;
	localparam logic [CFG_W-1:0] SCREEN_H_RST = 12'd600;
	localparam logic [COL_W-1:0] COL_MAX      = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X      = 3'd0,
		REG_ORIGIN_Y      = 3'd1,
		REG_SPAN_WIDTH    = 3'd2,
		REG_SPAN_HEIGHT   = 3'd3,
		REG_SCREEN_WIDTH  = 3'd4,
		REG_SCREEN_HEIGHT = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		PH_NODES = 4'b0001,
		PH_SKIP  = 4'b0010,
		PH_COPY  = 4'b0100,
		PH_COLOR = 4'b1000
	} phase_t;

	// geometry derived from the configuration registers
	typedef struct packed {
		logic [CFG_W-1:0]   origin_x;
		logic [LIM_W-1:0]   lim_width;
		logic [PIX_W-1:0]   top_row;
		logic [VROWS_W-1:0] vis_rows;
		logic [ROW_W-1:0]   skip_init;
		logic               empty;
		logic               x_clip;
	} geom_t;

	typedef struct packed {
		logic              emit;
		logic [PIX_W-1:0]  pixel_x;
		logic [PIX_W-1:0]  pixel_y;
		logic [WORD_W-1:0] color;
		logic              pixel_valid;
		logic              sprite_done;
		logic              aborted;
	} res_t;

endpackage

// ===== src/rscb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscb_if: stream channels of the sprite blitter
// valid/ready channels for sprite stream words and pixel results
// ----------------------------------------------------------------------------
interface rscb_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] stream_word;
	logic        start_of_sprite;

	modport source (output valid, stream_word, start_of_sprite, input ready);
	modport sink   (input valid, stream_word, start_of_sprite, output ready);
endinterface

interface rscb_out_if;
	logic        valid;
	logic        ready;
	logic [10:0] pixel_x;
	logic [10:0] pixel_y;
	logic [15:0] color;
	logic        pixel_valid;
	logic        sprite_done;
	logic        aborted;

	modport source (output valid, pixel_x, pixel_y, color, pixel_valid, sprite_done,
		aborted, input ready);
	modport sink   (input valid, pixel_x, pixel_y, color, pixel_valid, sprite_done,
		aborted, output ready);
endinterface

// ===== src/rscb_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscb_cfg: configuration registers and clip geometry
// holds the six registers and derives the clip window of the sprite
// ----------------------------------------------------------------------------
module rscb_cfg #(
	parameter int COORD_BITS = rscb_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rscb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rscb_pkg::CFG_W-1:0]          cfg_data,
	output rscb_pkg::geom_t                     geom
);
	import rscb_pkg::*;

	localparam logic [LIM_W-1:0] LIM_ONE = LIM_W'(1) << COORD_BITS;

	logic [CFG_W-1:0] origin_x_q, origin_y_q, screen_w_q, screen_h_q;
	logic [PIX_W-1:0] span_w_q, span_h_q;

	logic [LIM_W-1:0]  lim_w, lim_h;
	logic signed [19:0] l20, r20, t20, b20, bc20, vis20, limw20, limh20, top20;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			span_w_q   <= '0;
			span_h_q   <= '0;
			screen_w_q <= SCREEN_W_RST;
			screen_h_q <= SCREEN_H_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ORIGIN_X:      origin_x_q <= cfg_data;
				REG_ORIGIN_Y:      origin_y_q <= cfg_data;
				REG_SPAN_WIDTH:    span_w_q   <= cfg_data[PIX_W-1:0];
				REG_SPAN_HEIGHT:   span_h_q   <= cfg_data[PIX_W-1:0];
				REG_SCREEN_WIDTH:  screen_w_q <= cfg_data;
				REG_SCREEN_HEIGHT: screen_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// screen sizes clamp at 2^COORD_BITS
	always_comb begin
		lim_w = (LIM_W'(screen_w_q) > LIM_ONE) ? LIM_ONE : LIM_W'(screen_w_q);
		lim_h = (LIM_W'(screen_h_q) > LIM_ONE) ? LIM_ONE : LIM_W'(screen_h_q);
	end

	always_comb begin
		limw20 = $signed({4'b0000, lim_w});
		limh20 = $signed({4'b0000, lim_h});
		l20    = $signed({{8{origin_x_q[CFG_W-1]}}, origin_x_q});
		r20    = l20 + $signed({9'b0, span_w_q});
		t20    = $signed({{8{origin_y_q[CFG_W-1]}}, origin_y_q});
		top20  = origin_y_q[CFG_W-1] ? 20'sd0 : t20;
		b20    = t20 + $signed({9'b0, span_h_q});
		bc20   = (b20 > limh20) ? limh20 : b20;
		vis20  = bc20 - top20;

		geom.origin_x  = origin_x_q;
		geom.lim_width = lim_w;
		geom.top_row   = top20[PIX_W-1:0];
		geom.vis_rows  = vis20[VROWS_W-1:0];
		geom.skip_init = origin_y_q[CFG_W-1] ? ROW_W'(12'd0 - origin_y_q) : '0;
		geom.empty     = (span_w_q == '0) || (span_h_q == '0) || (r20 <= 20'sd0) ||
			(l20 >= limw20) || (vis20 <= 20'sd0);
		geom.x_clip    = (l20 < 20'sd0) || (r20 > limw20);
	end

endmodule

// ===== src/rscb_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rscb_decode: run-length stream decoder
// line, node and run state; one stream word per cycle while go is high, at most one result
// ----------------------------------------------------------------------------
module rscb_decode (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [rscb_pkg::WORD_W-1:0] word,
	input  logic                        start,
	input  rscb_pkg::geom_t             geom,
	output rscb_pkg::res_t              res
);
	import rscb_pkg::*;

	phase_t             ph_q, ph_d, ph_e;
	logic [ROW_W-1:0]   skip_q, skip_d, skip_e;
	logic [ROW_W-1:0]   row_q, row_d, row_e, row_inc;
	logic [WORD_W-1:0]  nodes_q, nodes_d, nodes_e, nodes_dec;
	logic [WORD_W-1:0]  run_q, run_d, run_e, run_dec;
	logic [COL_W-1:0]   col_q, col_d, col_e;
	logic [COL_W:0]     col_sum;
	logic               fin_q, fin_d;
	logic               active, do_end, er_done, done_flag, pix_vis;
	logic signed [19:0] x20;
	logic [PIX_W-1:0]   y11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PH_NODES;
			skip_q  <= '0;
			row_q   <= '0;
			nodes_q <= '0;
			run_q   <= '0;
			col_q   <= '0;
			fin_q   <= 1'b1;
		end else if (go) begin
			ph_q    <= ph_d;
			skip_q  <= skip_d;
			row_q   <= row_d;
			nodes_q <= nodes_d;
			run_q   <= run_d;
			col_q   <= col_d;
			fin_q   <= fin_d;
		end
	end

	// a start word restarts decode from clean state
	always_comb begin
		ph_e    = start ? PH_NODES : ph_q;
		skip_e  = start ? geom.skip_init : skip_q;
		row_e   = start ? '0 : row_q;
		nodes_e = start ? '0 : nodes_q;
		run_e   = start ? '0 : run_q;
		col_e   = start ? '0 : col_q;
		active  = start ? !geom.empty : !fin_q;

		row_inc   = row_e + ROW_W'(1);
		nodes_dec = nodes_e - WORD_W'(1);
		run_dec   = run_e - WORD_W'(1);
		er_done   = (skip_e == '0) && ($signed({2'b00, row_inc}) >= $signed(geom.vis_rows));
		col_sum   = {1'b0, col_e} + (COL_W+1)'(word);
		x20       = $signed({{8{geom.origin_x[CFG_W-1]}}, geom.origin_x}) +
			$signed({3'b000, col_e});
		y11       = geom.top_row + row_e[PIX_W-1:0];
	end

	always_comb begin
		ph_d    = ph_e;
		skip_d  = skip_e;
		row_d   = row_e;
		nodes_d = nodes_e;
		run_d   = run_e;
		col_d   = col_e;
		fin_d   = start ? geom.empty : fin_q;
		do_end  = 1'b0;
		pix_vis = 1'b0;
		res     = '0;

		if (start && geom.empty) begin
			res.emit        = 1'b1;
			res.sprite_done = 1'b1;
		end

		if (active) begin
			case (ph_e)
				PH_NODES: begin
					nodes_d = word;
					if (word == '0) begin
						do_end = 1'b1;
					end else begin
						ph_d = PH_SKIP;
					end
				end
				PH_SKIP: begin
					col_d = col_sum[COL_W] ? COL_MAX : col_sum[COL_W-1:0];
					ph_d  = PH_COPY;
				end
				PH_COPY: begin
					if (word == '0) begin
						if (skip_e == '0 && !geom.x_clip) begin
							// zero copy count on an unclipped visible row aborts
							fin_d           = 1'b1;
							res.emit        = 1'b1;
							res.sprite_done = 1'b1;
							res.aborted     = 1'b1;
						end else begin
							nodes_d = nodes_dec;
							if (nodes_dec == '0) begin
								do_end = 1'b1;
							end else begin
								ph_d = PH_SKIP;
							end
						end
					end else begin
						run_d = word;
						ph_d  = PH_COLOR;
					end
				end
				PH_COLOR: begin
					pix_vis = (skip_e == '0) && !x20[19] &&
						(x20 < $signed({4'b0000, geom.lim_width}));
					if (col_e != COL_MAX) begin
						col_d = col_e + COL_W'(1);
					end
					run_d = run_dec;
					if (run_dec == '0) begin
						nodes_d = nodes_dec;
						if (nodes_dec == '0) begin
							do_end = 1'b1;
						end else begin
							ph_d = PH_SKIP;
						end
					end
				end
				default: ;
			endcase

			// row end
			if (do_end) begin
				ph_d    = PH_NODES;
				col_d   = '0;
				nodes_d = '0;
				run_d   = '0;
				if (skip_e != '0) begin
					skip_d = skip_e - ROW_W'(1);
				end else begin
					row_d = row_inc;
					if (er_done) begin
						fin_d = 1'b1;
					end
				end
			end
		end

		done_flag = do_end && er_done;
		if (pix_vis) begin
			res.emit        = 1'b1;
			res.pixel_valid = 1'b1;
			res.pixel_x     = x20[PIX_W-1:0];
			res.pixel_y     = y11;
			res.color       = word;
			res.sprite_done = done_flag;
		end else if (done_flag) begin
			res.emit        = 1'b1;
			res.sprite_done = 1'b1;
		end
	end

endmodule

// ===== src/rle_sprite_clip_blit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rle_sprite_clip_blit_core: run-length transparent sprite blitter
// decodes a sprite stream and emits clipped screen pixels
// ----------------------------------------------------------------------------
// The block takes one 16-bit stream word per clock and gives at most one
// result per word: a visible pixel with its screen position and color, or a
// done marker at the end of the sprite, at an abort on a zero copy count, or
// right at the start word when the sprite is empty or off-screen. Words that
// arrive after the sprite has finished and carry no start mark are taken and
// dropped. The word passes an input register, then a result register; the
// stream side keeps going at one word per cycle as long as the result side
// takes its transactions, since all decode work is counter updates and compares
// between those two registers. Configuration is written through a plain write
// port; the user writes it only while no sprite is in flight, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rle_sprite_clip_blit_core #(
	parameter int COORD_BITS = rscb_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rscb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rscb_pkg::CFG_W-1:0]     cfg_data,
	rscb_in_if.sink                        stream,
	rscb_out_if.source                     pixels
);
	import rscb_pkg::*;

	geom_t              geom;
	res_t               res;

	// input stage
	logic               valid_s1;
	logic [WORD_W-1:0]  word_s1;
	logic               start_s1;

	// result register
	logic               out_valid_q;
	res_t               out_q;

	logic               advance;
	logic               go;

	rscb_cfg #(
		.COORD_BITS (COORD_BITS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	// the word in the input stage moves on whenever the result register is free
	assign advance      = !out_valid_q || pixels.ready;
	assign go           = valid_s1 && advance;
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready) begin
			word_s1  <= stream.stream_word;
			start_s1 <= stream.start_of_sprite;
		end
	end

	rscb_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.word   (word_s1),
		.start  (start_s1),
		.geom   (geom),
		.res    (res)
	);

	// result register, marked valid only when the word actually produces a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= go && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign pixels.valid       = out_valid_q;
	assign pixels.pixel_x     = out_q.pixel_x;
	assign pixels.pixel_y     = out_q.pixel_y;
	assign pixels.color       = out_q.color;
	assign pixels.pixel_valid = out_q.pixel_valid;
	assign pixels.sprite_done = out_q.sprite_done;
	assign pixels.aborted     = out_q.aborted;

`ifndef SYNTH
	// an abort always ends the sprite and never writes a pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && pixels.aborted |-> pixels.sprite_done && !pixels.pixel_valid)
		else $error("abort result without done or with a pixel");

	// a written pixel lies inside the clipped screen width
	assert property (@(posedge clk) disable iff (!arst_n)
		pixels.valid && pixels.pixel_valid |->
			({5'b00000, pixels.pixel_x} < geom.lim_width))
		else $error("pixel outside the screen width");

	// an empty result register never holds back the stream side
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> stream.ready)
		else $error("stream stalled with free result register");

	// a result that is not taken stays in place
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pixels.ready |=> out_valid_q && $stable(out_q))
		else $error("pending result changed");
`endif

endmodule
